### rtl/core/brms_pkg.sv
`default_nettype none

package brms_pkg;

    // block length limit and derived widths
    localparam int MAX_BLOCK_SAMPLES = 65536;
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W;
    // largest square is 2^30, so 31 bits
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    localparam int CNT_W    = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int SUM_W    = $clog2(MAX_BLOCK_SAMPLES) + SQ_W;

    // square root of a mean that is at most 2^30
    localparam int ROOT_W   = 16;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int RMS_W    = 16;

    // step counter covers the longer of the two iterations
    localparam int STEP_W   = $clog2(SUM_W);

    // queue of closed blocks between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0] square_sum;
        logic [CNT_W-1:0] sample_count;
        logic             overflowed;
    } brms_block_t;

    typedef struct packed {
        logic        push;
        brms_block_t entry;
    } brms_push_t;

endpackage

`default_nettype wire

### rtl/core/brms_front.sv
`default_nettype none

module brms_front
    import brms_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       sample_valid,
    output logic                            sample_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       last,
    input  wire logic                       queue_full,
    output brms_push_t                      push
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [SQ_W-1:0]   s1_square_reg;
    logic              s1_last_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              ovf_reg;
    logic              ovf_next;

    logic              accept;
    logic              drain;
    logic [MAG_W-1:0]  mag;
    logic [2*MAG_W-1:0] product;
    logic [SUM_W-1:0]  sum_acc;
    logic [CNT_W-1:0]  count_acc;
    logic              ovf_acc;

    // a closing sample waits in stage one while the queue is full
    assign sample_stall = s1_valid_reg && s1_last_reg && queue_full;
    assign accept       = sample_valid && !sample_stall;
    assign drain        = s1_valid_reg && !(s1_last_reg && queue_full);

    // two's complement magnitude, -32768 gives 32768
    assign mag     = sample[SAMPLE_W-1] ? (~sample + MAG_W'(1)) : sample;
    assign product = mag * mag;

    always_comb
    begin
        if (count_reg < CNT_W'(MAX_BLOCK_SAMPLES))
        begin
            sum_acc   = sum_reg + SUM_W'(s1_square_reg);
            count_acc = count_reg + CNT_W'(1);
            ovf_acc   = ovf_reg;
        end
        else
        begin
            sum_acc   = sum_reg;
            count_acc = count_reg;
            ovf_acc   = 1'b1;
        end
    end

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        push.push  = 1'b0;
        push.entry.square_sum   = sum_acc;
        push.entry.sample_count = count_acc;
        push.entry.overflowed   = ovf_acc;
        if (drain)
        begin
            if (s1_last_reg)
            begin
                push.push  = 1'b1;
                sum_next   = '0;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                sum_next   = sum_acc;
                count_next = count_acc;
                ovf_next   = ovf_acc;
            end
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (drain)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_square_reg <= product[SQ_W-1:0];
            s1_last_reg   <= last;
        end
    end

endmodule

`default_nettype wire

### rtl/core/brms_queue.sv
`default_nettype none

module brms_queue
    import brms_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire brms_push_t  push,
    output logic             full,
    output logic             head_valid,
    output brms_block_t      head,
    input  wire logic        pop
);

    brms_block_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  fill_reg;
    logic [QCNT_W-1:0]  fill_next;

    assign full       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push.push && !pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (pop && !push.push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            entry_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

`default_nettype wire

### rtl/core/brms_back.sv
`default_nettype none

module brms_back
    import brms_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               head_valid,
    input  wire brms_block_t        head,
    output logic                    pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [RMS_W-1:0]        rms,
    output logic                    overflow
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    // divider: dividend shifts out the top while quotient bits shift in
    logic [SUM_W-1:0]    quo_reg;
    logic [SUM_W-1:0]    quo_next;
    logic [CNT_W-1:0]    div_rem_reg;
    logic [CNT_W-1:0]    div_rem_next;
    logic [CNT_W-1:0]    divisor_reg;
    logic                zero_reg;
    logic                ovf_reg;

    // square root: radicand shifts out two bits a step
    logic [RAD_W-1:0]    rad_reg;
    logic [RAD_W-1:0]    rad_next;
    logic [ROOT_W+1:0]   sq_rem_reg;
    logic [ROOT_W+1:0]   sq_rem_next;
    logic [ROOT_W-1:0]   root_reg;
    logic [ROOT_W-1:0]   root_next;

    logic                result_valid_reg;
    logic                result_valid_next;
    logic [RMS_W-1:0]    rms_reg;
    logic                overflow_reg;

    logic [CNT_W:0]      div_shift;
    logic                div_ge;
    logic [CNT_W:0]      div_diff;
    logic [ROOT_W+1:0]   sq_shift;
    logic [ROOT_W+1:0]   sq_trial;
    logic                sq_ge;
    logic                load_out;

    assign pop          = head_valid && (state_reg == ST_IDLE);
    assign load_out     = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);
    assign result_valid = result_valid_reg;
    assign rms          = rms_reg;
    assign overflow     = overflow_reg;

    // one restoring division step
    assign div_shift = {div_rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});
    assign div_diff  = div_shift - {1'b0, divisor_reg};

    // one digit of the root
    assign sq_shift = {sq_rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        quo_next     = quo_reg;
        div_rem_next = div_rem_reg;
        rad_next     = rad_reg;
        sq_rem_next  = sq_rem_reg;
        root_next    = root_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next   = ST_DIV;
                    step_next    = '0;
                    quo_next     = head.square_sum;
                    div_rem_next = '0;
                end
            end
            ST_DIV:
            begin
                quo_next     = {quo_reg[SUM_W-2:0], div_ge};
                div_rem_next = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next  = ST_ROOT;
                    step_next   = '0;
                    rad_next    = zero_reg ? '0 : quo_next[RAD_W-1:0];
                    sq_rem_next = '0;
                    root_next   = '0;
                end
            end
            ST_ROOT:
            begin
                rad_next    = {rad_reg[RAD_W-3:0], 2'b00};
                sq_rem_next = sq_ge ? (sq_shift - sq_trial) : sq_shift;
                root_next   = {root_reg[ROOT_W-2:0], sq_ge};
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg    <= step_next;
        quo_reg     <= quo_next;
        div_rem_reg <= div_rem_next;
        rad_reg     <= rad_next;
        sq_rem_reg  <= sq_rem_next;
        root_reg    <= root_next;
        if (pop)
        begin
            divisor_reg <= head.sample_count;
            zero_reg    <= (head.sample_count == '0);
            ovf_reg     <= head.overflowed;
        end
        if (load_out)
        begin
            rms_reg      <= RMS_W'(root_reg);
            overflow_reg <= ovf_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/core/block_rms_level.sv
// Block RMS level meter for signed 16-bit PCM. Samples are taken one per clock
// on the sample channel unless it stalls; the sample marked last closes the
// block and, once the block is worked out, exactly one transaction carries
// rms = floor(sqrt(floor(sum of squares / count))) and an overflow flag on the
// result channel. A block longer than MAX_BLOCK_SAMPLES keeps only its first
// MAX_BLOCK_SAMPLES samples and reports overflow = 1. The front squares and
// accumulates at one sample per cycle unless stalled and hands each closed
// block to a two-entry queue; the back then runs a restoring divider (one
// quotient bit per cycle) followed by a digit-by-digit square root (one root
// bit per cycle), and takes a new block from the queue only once it is idle.
// The sample channel stalls only when a closing sample finds both queue entries
// taken, which happens under a run of short blocks that close faster than the
// back works them out or while the result channel holds back finished results.
`default_nettype none

module block_rms_level
    import brms_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    // sample channel
    input  wire logic                       sample_valid,
    output logic                            sample_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic                       last,

    // result channel
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [RMS_W-1:0]                rms,
    output logic                            overflow
);

    brms_push_t   push;
    logic         queue_full;
    logic         head_valid;
    brms_block_t  head;
    logic         pop;

    // front: magnitude, square, running sum and count per block
    brms_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .last         (last),
        .queue_full   (queue_full),
        .push         (push)
    );

    // closed blocks waiting for the divider
    brms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // back: mean by division, then the root, into the output register
    brms_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .rms          (rms),
        .overflow     (overflow)
    );

    // a closed block is never written into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> !queue_full || pop)
        else $error("block pushed into full queue");

    // the sample side only stalls because of back pressure from the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> queue_full)
        else $error("sample stall without a full queue");

    // the root of a mean of 16-bit squares never exceeds 32768
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (rms <= RMS_W'(32768)))
        else $error("rms out of range");

    // a closed block always holds at least one counted sample
    assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> (push.entry.sample_count != '0))
        else $error("empty block closed");

endmodule

`default_nettype wire

### verif/block_rms_level_test.sv
module block_rms_level_test;
    timeunit 1ns;
    timeprecision 1ps;

    import brms_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    // watchdog limit, even a run with one reading per sample stays far below this
    localparam int CYCLE_LIMIT  = 1000000;
    // a reading comes once its block is worked out, two closed blocks can queue up
    localparam int DRAIN_CYCLES = 250;
    // first trial bit of the digit-by-digit root
    localparam longint unsigned ROOT_TOP_BIT = 64'd1 << 30;

    // one pcm transaction as queued for the driver
    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       closes;
    } pcm_item_t;

    // one level reading that the block should report
    typedef struct {
        logic [RMS_W-1:0] level;
        logic             over;
    } level_reading_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample       = '0;
    logic                       last         = 1'b0;

    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic [RMS_W-1:0]           rms;
    logic                       overflow;

    pcm_item_t      pcm_pending[$];
    level_reading_t levels_due[$];
    pcm_item_t      next_item;
    level_reading_t due_reading;

    // running block state of the predictor
    logic [SUM_W-1:0] blk_square_sum = '0;
    logic [CNT_W-1:0] blk_count      = '0;
    logic             blk_over       = 1'b0;

    // percentage of cycles in which each side holds back
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    int mismatches  = 0;
    int cycle_count = 0;

    block_rms_level dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .rms          (rms),
        .overflow     (overflow)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // floor square root, one root bit per trial
    function automatic logic [RMS_W-1:0] floor_root(input longint unsigned radicand);
        longint unsigned probe;
        longint unsigned root;
        longint unsigned rest;
        probe = ROOT_TOP_BIT;
        root  = 0;
        rest  = radicand;
        while (probe > radicand)
            probe >>= 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest -= root + probe;
                root  = (root >> 1) + probe;
            end
            else
            begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root[RMS_W-1:0];
    endfunction

    // fold one accepted sample into the block and, on the closing one, queue its level
    task automatic predict_block_level(input logic signed [SAMPLE_W-1:0] value,
                                       input logic closes);
        longint          signed_value;
        longint unsigned magnitude;
        longint unsigned mean_square;
        level_reading_t  reading;
        signed_value = value;
        magnitude    = (signed_value < 0) ? -signed_value : signed_value;
        // a full block refuses further samples, the closing one included
        if (blk_count < MAX_BLOCK_SAMPLES)
        begin
            blk_square_sum = blk_square_sum + SUM_W'(magnitude * magnitude);
            blk_count      = blk_count + 1'b1;
        end
        else
        begin
            blk_over = 1'b1;
        end
        if (closes)
        begin
            mean_square   = (blk_count != 0) ? (64'(blk_square_sum) / 64'(blk_count)) : 0;
            reading.level = floor_root(mean_square);
            reading.over  = blk_over;
            levels_due.push_back(reading);
            blk_square_sum = '0;
            blk_count      = '0;
            blk_over       = 1'b0;
        end
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input logic closes);
        pcm_item_t item;
        item.value  = value;
        item.closes = closes;
        pcm_pending.push_back(item);
    endtask

    // extremes, tiny values and full-range noise
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return -16'sd32768;
        else if (roll < 16)
            return 16'sd32767;
        else if (roll < 22)
            return SAMPLE_W'($urandom_range(2)) - 16'sd1;
        else if (roll < 40)
            return SAMPLE_W'($urandom_range(64)) - 16'sd32;
        else
            return SAMPLE_W'($urandom);
    endfunction

    // mostly short blocks so that readings come often, a few longer ones
    task automatic add_random_blocks(input int item_goal);
        int added;
        int roll;
        int len;
        added = 0;
        while (added < item_goal)
        begin
            roll = $urandom_range(99);
            if (roll < 80)
                len = $urandom_range(6, 1);
            else if (roll < 97)
                len = $urandom_range(40, 7);
            else
                len = $urandom_range(200, 41);
            for (int k = 0; k < len; k++)
                push_sample(pick_sample(), k == len - 1);
            added += len;
        end
    endtask

    task automatic wait_for_drain();
        while (pcm_pending.size() != 0 || sample_valid)
            @(posedge clk);
    endtask

    // driver: a new transaction is offered only once the previous one has gone
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
            last         <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                predict_block_level(sample, last);
            if (!sample_valid || !sample_stall)
            begin
                if (pcm_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    next_item    = pcm_pending.pop_front();
                    sample_valid <= 1'b1;
                    sample       <= next_item.value;
                    last         <= next_item.closes;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: each accepted reading against the oldest one due
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (levels_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result rms=%0d overflow=%0b",
                                              rms, overflow));
                end
                else
                begin
                    due_reading = levels_due.pop_front();
                    if (rms !== due_reading.level)
                        report_mismatch($sformatf("rms got %0d want %0d",
                                                  rms, due_reading.level));
                    if (overflow !== due_reading.over)
                        report_mismatch($sformatf("overflow got %0b want %0b",
                                                  overflow, due_reading.over));
                end
            end
            result_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        // phase one: sender idles a little, receiver a lot
        tx_idle_pct = 23;
        rx_idle_pct = 88;

        // full-scale single-sample blocks, both polarities, zero and minus one
        push_sample(-16'sd32768, 1'b1);
        push_sample(16'sd32767, 1'b1);
        push_sample(16'sd0, 1'b1);
        push_sample(-16'sd1, 1'b1);
        // opposite signs square alike
        push_sample(16'sd1, 1'b0);
        push_sample(-16'sd1, 1'b1);
        push_sample(16'sd32767, 1'b0);
        push_sample(-16'sd32768, 1'b1);
        // two means of squares that truncate
        push_sample(16'sd3, 1'b0);
        push_sample(16'sd4, 1'b0);
        push_sample(16'sd5, 1'b1);
        push_sample(16'sd2, 1'b0);
        push_sample(16'sd3, 1'b1);
        // largest squares over several samples
        for (int k = 0; k < 4; k++)
            push_sample(-16'sd32768, k == 3);
        push_sample(16'sd100, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b1);
        push_sample(-16'sd12345, 1'b1);

        add_random_blocks(170);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        wait_for_drain();

        // phase two: roles of the two sides swapped
        tx_idle_pct = 88;
        rx_idle_pct = 23;
        add_random_blocks(170);
        wait_for_drain();

        // phase three: no idling at all
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        add_random_blocks(170);
        wait_for_drain();

        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (levels_due.size() != 0)
            report_mismatch($sformatf("%0d readings never arrived", levels_due.size()));

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
